@@ hw/rtl/mlt_pkg.sv @@
// Shared types, constants and helpers of the MAC learning table.
// No dependencies; every other file of the block imports this package.
package mlt_pkg;

  localparam int HASH_BITS        = 11;
  localparam int SLOTS_PER_BUCKET = 4;
  localparam int BUCKETS          = 1 << HASH_BITS;
  localparam int SLOT_W           = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int CNT_W            = $clog2(SLOTS_PER_BUCKET + 1);

  localparam logic [19:0] AGING_MIN   = 20'd10;
  localparam logic [19:0] AGING_MAX   = 20'd1000000;
  localparam logic [19:0] AGING_RESET = 20'd300;

  localparam logic [1:0] CMD_LEARN  = 2'd0;
  localparam logic [1:0] CMD_ACCESS = 2'd1;
  localparam logic [1:0] CMD_AGE    = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [2:0] ST_UNCHANGED = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_CREATED   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_DROPPED   = 3'd4;
  localparam logic [2:0] ST_REFRESHED = 3'd5;
  localparam logic [2:0] ST_IGNORED   = 3'd6;
  localparam logic [2:0] ST_SWEPT     = 3'd7;

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] station_mac;
    logic [7:0]  vlan_fid;
    logic        vlan_dropped;
    logic [31:0] dest_mask;
    logic        is_dynamic;
    logic [10:0] bucket_index;
    logic [1:0]  slot_index;
    logic [4:0]  port_number;
    logic [31:0] current_time;
  } mlt_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] result_bucket;
    logic [1:0]  result_slot;
    logic [2:0]  removed_count;
    logic [2:0]  occupied_count;
  } mlt_rsp_t;

  typedef struct packed {
    logic        valid;
    logic [47:0] mac;
    logic [7:0]  fid;
    logic [31:0] ports;
    logic        dyn;
    logic [31:0] last_seen;
  } slot_t;

  typedef slot_t [SLOTS_PER_BUCKET-1:0] row_t;

  function automatic logic [2:0] sat_cnt(input logic [CNT_W-1:0] cnt);
    logic [2:0] res;
    if (32'(cnt) > 7) res = 3'd7;
    else res = 3'(cnt);
    return res;
  endfunction

endpackage

@@ hw/rtl/mlt_if.sv @@
// Valid/ready channels of the MAC learning table: request, response, config.
// Depends on mlt_pkg for the payload types.
interface mlt_req_if;
  import mlt_pkg::*;
  logic     valid;
  logic     ready;
  mlt_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlt_rsp_if;
  import mlt_pkg::*;
  logic     valid;
  logic     ready;
  mlt_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlt_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] aging_limit;
  modport source (output valid, output aging_limit, input ready);
  modport sink (input valid, input aging_limit, output ready);
endinterface

@@ hw/rtl/mac_learning_table_with_aging.sv @@
// MAC learning table of hash buckets with aging: top level and bucket sequencer.
// Depends on mlt_pkg and the channel interfaces in mlt_if.sv.
//
// Each request works on one bucket row of SLOTS_PER_BUCKET slots held in one wide memory.
// The row is read on acceptance, the slots are then examined one per cycle by a single
// compare/subtract unit, and the row is written back in S_DONE; the response word is
// registered. A new request is taken only in S_IDLE, after the last one's write-back;
// the next request may be taken while the response word still waits, but its
// write-back holds until that word is collected. After reset a clearing pass
// invalidates every row; no request is taken meanwhile, while configuration writes
// are accepted throughout.
module mac_learning_table_with_aging (
  input  logic    clk_i,
  input  logic    rst_ni,
  mlt_req_if.sink   in_i,
  mlt_rsp_if.source out_o,
  mlt_cfg_if.sink   cfg_i
);
  import mlt_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0]           state_q, state_d;
  logic [HASH_BITS-1:0] clr_q;
  logic [19:0]          aging_q;
  mlt_req_t             req_q;
  logic [HASH_BITS-1:0] bucket_q;
  logic [31:0]          thr_q, pbit_q;
  row_t                 mem_q [BUCKETS];
  row_t                 rdata_q, nrow_q, wrow;
  logic [SLOT_W-1:0]    r_q, fslot_q, free_slot_q, acc_slot;
  logic                 found_q, fdiff_q, free_q;
  logic [CNT_W-1:0]     occ_q, rem_q;
  logic                 out_valid_q;
  mlt_rsp_t             rsp_q, rsp_d;
  logic                 accept, sweep, drop, acc_ok, done_go;
  slot_t                e, ea;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = rsp_q;
  // hold the write-back until the response register is free
  assign done_go     = !out_valid_q || out_o.ready;

  assign sweep = (req_q.command == CMD_AGE) || (req_q.command == CMD_CLEAR);
  assign e     = rdata_q[r_q];
  // shared unit: wrap-safe age compare or exact single-port match
  always_comb begin
    if (req_q.command == CMD_AGE) drop = e.dyn && (e.last_seen - thr_q) >= 32'h8000_0000;
    else drop = e.dyn && (e.ports == pbit_q);
  end

  assign acc_slot = SLOT_W'(req_q.slot_index);
  assign ea       = rdata_q[acc_slot];
  assign acc_ok   = (32'(req_q.slot_index) < SLOTS_PER_BUCKET) && ea.valid && ea.dyn;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:   if (clr_q == '1) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_SCAN;
      S_SCAN:  if (r_q == SLOT_W'(SLOTS_PER_BUCKET - 1)) state_d = S_DONE;
      S_DONE:  if (done_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // build the row to write back and the response word
  always_comb begin
    wrow                 = rdata_q;
    rsp_d.status         = ST_UNCHANGED;
    rsp_d.result_bucket  = 11'(bucket_q);
    rsp_d.result_slot    = 2'd0;
    rsp_d.removed_count  = 3'd0;
    rsp_d.occupied_count = sat_cnt(occ_q);
    case (req_q.command)
      CMD_LEARN: begin
        if (req_q.vlan_dropped) begin
          rsp_d.status = ST_DROPPED;
        end else if (found_q) begin
          rsp_d.result_slot = 2'(fslot_q);
          if (fdiff_q) begin
            wrow[fslot_q].ports     = req_q.dest_mask;
            wrow[fslot_q].last_seen = req_q.current_time;
            rsp_d.status            = ST_UPDATED;
          end
        end else if (free_q) begin
          wrow[free_slot_q] = '{valid: 1'b1, mac: req_q.station_mac, fid: req_q.vlan_fid,
                                ports: req_q.dest_mask, dyn: req_q.is_dynamic,
                                last_seen: req_q.current_time};
          rsp_d.status         = ST_CREATED;
          rsp_d.result_slot    = 2'(free_slot_q);
          rsp_d.occupied_count = sat_cnt(occ_q + CNT_W'(1));
        end else begin
          rsp_d.status = ST_FULL;
        end
      end
      CMD_ACCESS: begin
        rsp_d.result_slot = req_q.slot_index;
        rsp_d.status      = ST_IGNORED;
        if (acc_ok) begin
          wrow[acc_slot].last_seen = req_q.current_time;
          rsp_d.status             = ST_REFRESHED;
        end
      end
      default: begin
        wrow                = nrow_q;
        rsp_d.status        = ST_SWEPT;
        rsp_d.removed_count = sat_cnt(rem_q);
      end
    endcase
  end

  // bucket memory: clearing pass, write-back, registered read on acceptance
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLR) mem_q[clr_q] <= '0;
    else if (state_q == S_DONE && done_go) mem_q[bucket_q] <= wrow;
    if (accept) rdata_q <= mem_q[HASH_BITS'(in_i.data.bucket_index)];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= in_i.data;
      bucket_q <= HASH_BITS'(in_i.data.bucket_index);
      thr_q    <= in_i.data.current_time - {12'd0, aging_q};
      pbit_q   <= 32'd1 << in_i.data.port_number;
      for (int i = 0; i < SLOTS_PER_BUCKET; i++) nrow_q[i].valid <= 1'b0;
    end else if (state_q == S_SCAN && sweep && e.valid && !drop) begin
      nrow_q[SLOT_W'(occ_q)] <= e;
    end
    if (state_q == S_SCAN && !found_q && e.valid && e.mac == req_q.station_mac &&
        e.fid == req_q.vlan_fid) begin
      fslot_q <= r_q;
      fdiff_q <= e.ports != req_q.dest_mask;
    end
    if (state_q == S_SCAN && !free_q && !e.valid) free_slot_q <= r_q;
    if (state_q == S_DONE && done_go) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      aging_q     <= AGING_RESET;
      r_q         <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      occ_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + HASH_BITS'(1);
      if (cfg_i.valid && cfg_i.aging_limit >= AGING_MIN && cfg_i.aging_limit <= AGING_MAX) begin
        aging_q <= cfg_i.aging_limit;
      end
      if (accept) begin
        r_q     <= '0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
        occ_q   <= '0;
        rem_q   <= '0;
      end else if (state_q == S_SCAN) begin
        r_q <= r_q + SLOT_W'(1);
        if (e.valid && e.mac == req_q.station_mac && e.fid == req_q.vlan_fid) found_q <= 1'b1;
        if (!e.valid) free_q <= 1'b1;
        // sweeps count kept entries, the others count every valid one
        if (e.valid && !(sweep && drop)) occ_q <= occ_q + CNT_W'(1);
        if (e.valid && sweep && drop) rem_q <= rem_q + CNT_W'(1);
      end
      if (state_q == S_DONE && done_go) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

endmodule
